// ----- src/dhd_pkg.sv -----
// Shared widths and codes for the detection head decode unit.
package dhd_pkg;

    // Input element and score widths
    localparam int VALUE_W      = 16;
    localparam int FRAC_BITS    = 12;   // Q4.12 inverse ratio
    localparam int RATIO_W      = 16;
    localparam int PAD_W        = 12;
    localparam int CLASS_W      = 8;
    localparam int ANCHOR_OUT_W = 15;
    localparam int SIZE_OUT_W   = 15;
    localparam int EDGE_OUT_W   = 16;

    // Corner after centre-to-edge conversion: (2*x - w) / 32, 13 bits signed
    localparam int COORD_W = 13;
    // Box size in whole pixels: w >> 4
    localparam int SIZE_PX_W = 12;

    // Row element positions
    localparam int POS_W          = 9;  // up to 4 + 255
    localparam int BOX_FIELDS     = 4;
    localparam int OBJ_POS        = 4;
    localparam int FIRST_CLASS_POS = 5;
    localparam int MAX_CLASSES    = 255;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SCORE_THRESHOLD = 3'd0,
        CFG_CLASS_COUNT     = 3'd1,
        CFG_PAD_WIDTH       = 3'd2,
        CFG_PAD_HEIGHT      = 3'd3,
        CFG_INVERSE_RATIO   = 3'd4
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam logic [15:0]          RST_SCORE_THRESHOLD = 16'd16384;
    localparam logic [CLASS_W-1:0]   RST_CLASS_COUNT     = 8'd80;
    localparam logic [RATIO_W-1:0]   RST_INVERSE_RATIO   = 16'd4096;

endpackage

// ----- src/detection_head_decode_unit.sv -----
// Top level of the detection head decode unit: row tracking, class maximum and box output.
//
// Streams a detection head's output one 16-bit value per transaction, row by row:
// x, y, w, h (Q12.4 pixels), objectness, then class_count class scores (Q0.16).
// s_tuser[0] marks the first value of a frame and restarts the row and anchor counts.
// One value is taken every cycle unless the input stalls; a row of 5 + class_count
// values (a class_count of zero counts as one) yields at most one box transaction
// when (best class score * objectness) >> 16 is strictly above score_threshold.
// The path has two register stages: a row-end capture register, then the result
// register that holds m_tdata; the input stalls only when both are full and the
// master side is not ready. Box edges are truncated toward zero, padding is
// removed and the Q4.12 inverse ratio applied, then edges saturate to 16-bit
// signed and sizes to 32767. Configuration writes take effect at once and should
// only be made while no row is in flight.
module detection_head_decode_unit
    import dhd_pkg::*;
#(
    parameter int MAX_ANCHORS = 32768
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // Configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [15:0]            s_tdata,   // [15:0] value
    input  logic [0:0]             s_tuser,   // [0] frame_start

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [14:0] anchor_index, [22:15] class_id, [38:23] score, [54:39] box_left,
    // [70:55] box_top, [85:71] box_width, [100:86] box_height, [103:101] zero
    output logic [103:0]           m_tdata
);

    localparam int AW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;

    // Configuration registers
    logic [15:0]        score_threshold_reg;
    logic [CLASS_W-1:0] class_count_reg;
    logic [PAD_W-1:0]   pad_width_reg;
    logic [PAD_W-1:0]   pad_height_reg;
    logic [RATIO_W-1:0] inverse_ratio_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            score_threshold_reg <= RST_SCORE_THRESHOLD;
            class_count_reg     <= RST_CLASS_COUNT;
            pad_width_reg       <= '0;
            pad_height_reg      <= '0;
            inverse_ratio_reg   <= RST_INVERSE_RATIO;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_SCORE_THRESHOLD: score_threshold_reg <= cfg_wdata;
                CFG_CLASS_COUNT:     class_count_reg     <= cfg_wdata[CLASS_W-1:0];
                CFG_PAD_WIDTH:       pad_width_reg       <= cfg_wdata[PAD_W-1:0];
                CFG_PAD_HEIGHT:      pad_height_reg      <= cfg_wdata[PAD_W-1:0];
                CFG_INVERSE_RATIO:   inverse_ratio_reg   <= cfg_wdata[RATIO_W-1:0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Row tracking, done on each accepted transaction
    // ------------------------------------------------------------------
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [AW-1:0]      anchor_reg, anchor_next;
    logic [VALUE_W-1:0] box_reg [BOX_FIELDS];
    logic [VALUE_W-1:0] obj_reg;
    logic [VALUE_W-1:0] best_reg, best_next;
    logic [CLASS_W-1:0] best_idx_reg, best_idx_next;

    logic               s_accept;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos_cur;
    logic [AW-1:0]      anchor_cur;
    logic [CLASS_W-1:0] cc_eff;
    logic [POS_W-1:0]   last_pos;
    logic               row_end;

    // Stage handshake
    logic snap_valid_reg;
    logic snap_advance;

    assign snap_advance = !m_tvalid || m_tready;
    assign s_tready     = !snap_valid_reg || snap_advance;
    assign s_accept     = s_tvalid && s_tready;
    assign value        = s_tdata[VALUE_W-1:0];

    always_comb begin
        // Frame start clears position and anchor before the value is taken
        pos_cur    = s_tuser[0] ? '0 : pos_reg;
        anchor_cur = s_tuser[0] ? '0 : anchor_reg;

        if (class_count_reg == '0) begin
            cc_eff = CLASS_W'(1);
        end else if (32'(class_count_reg) > MAX_CLASSES) begin
            cc_eff = CLASS_W'(MAX_CLASSES);
        end else begin
            cc_eff = class_count_reg;
        end
        last_pos = POS_W'(OBJ_POS) + POS_W'(cc_eff);
        row_end  = pos_cur >= last_pos;

        // Running first maximum over the class scores
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        if (pos_cur == POS_W'(FIRST_CLASS_POS)) begin
            best_next     = value;
            best_idx_next = '0;
        end else if (pos_cur > POS_W'(FIRST_CLASS_POS) && value > best_reg) begin
            best_next     = value;
            best_idx_next = CLASS_W'(pos_cur - POS_W'(FIRST_CLASS_POS));
        end

        if (row_end) begin
            pos_next    = '0;
            anchor_next = (anchor_cur == AW'(MAX_ANCHORS - 1)) ? '0 : AW'(anchor_cur + 1'b1);
        end else begin
            pos_next    = POS_W'(pos_cur + 1'b1);
            anchor_next = anchor_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            anchor_reg <= '0;
        end else if (s_accept) begin
            pos_reg    <= pos_next;
            anchor_reg <= anchor_next;
        end
    end

    // Payload registers: written only by accepted values in their row slot
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (pos_cur < POS_W'(BOX_FIELDS)) begin
                box_reg[pos_cur[1:0]] <= value;
            end
            if (pos_cur == POS_W'(OBJ_POS)) begin
                obj_reg <= value;
            end
            best_reg     <= best_next;
            best_idx_reg <= best_idx_next;
        end
    end

    // ------------------------------------------------------------------
    // Row-end capture: freeze what the result needs, corners already formed
    // ------------------------------------------------------------------
    logic        [ANCHOR_OUT_W-1:0] snap_anchor_reg;
    logic        [CLASS_W-1:0]      snap_class_reg;
    logic        [VALUE_W-1:0]      snap_best_reg;
    logic        [VALUE_W-1:0]      snap_obj_reg;
    logic signed [COORD_W-1:0]      snap_left_reg;
    logic signed [COORD_W-1:0]      snap_top_reg;
    logic        [SIZE_PX_W-1:0]    snap_w_reg;
    logic        [SIZE_PX_W-1:0]    snap_h_reg;

    logic signed [COORD_W+4:0] left_d, top_d;
    logic signed [COORD_W-1:0] left_c, top_c;

    // Corner = (2*centre - size) / 32, truncated toward zero
    always_comb begin
        left_d = $signed({1'b0, box_reg[0], 1'b0}) - $signed({2'b00, box_reg[2]});
        top_d  = $signed({1'b0, box_reg[1], 1'b0}) - $signed({2'b00, box_reg[3]});
        left_c = COORD_W'((left_d + $signed({{(COORD_W){1'b0}}, {5{left_d[COORD_W+4]}}}))
                          >>> 5);
        top_c  = COORD_W'((top_d + $signed({{(COORD_W){1'b0}}, {5{top_d[COORD_W+4]}}}))
                          >>> 5);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (s_accept && row_end) begin
            snap_valid_reg <= 1'b1;
        end else if (snap_advance) begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && row_end) begin
            snap_anchor_reg <= ANCHOR_OUT_W'(anchor_cur);
            snap_class_reg  <= best_idx_next;
            snap_best_reg   <= best_next;
            snap_obj_reg    <= obj_reg;
            snap_left_reg   <= left_c;
            snap_top_reg    <= top_c;
            snap_w_reg      <= box_reg[2][VALUE_W-1:4];
            snap_h_reg      <= box_reg[3][VALUE_W-1:4];
        end
    end

    // ------------------------------------------------------------------
    // Score, threshold and unscaling into the result register
    // ------------------------------------------------------------------
    logic [2*VALUE_W-1:0]         score_prod;
    logic [VALUE_W-1:0]           score;
    logic                         emit;
    logic signed [EDGE_OUT_W-1:0] left_u, top_u, w_u, h_u;

    assign score_prod = snap_best_reg * snap_obj_reg;
    assign score      = score_prod[2*VALUE_W-1:VALUE_W];
    assign emit       = score > score_threshold_reg;

    dhd_unscale u_unscale_left (
        .coord         (snap_left_reg),
        .pad           (pad_width_reg),
        .inverse_ratio (inverse_ratio_reg),
        .result        (left_u)
    );

    dhd_unscale u_unscale_top (
        .coord         (snap_top_reg),
        .pad           (pad_height_reg),
        .inverse_ratio (inverse_ratio_reg),
        .result        (top_u)
    );

    // Sizes are never negative, so the upper clamp alone applies
    dhd_unscale u_unscale_width (
        .coord         ($signed({1'b0, snap_w_reg})),
        .pad           ('0),
        .inverse_ratio (inverse_ratio_reg),
        .result        (w_u)
    );

    dhd_unscale u_unscale_height (
        .coord         ($signed({1'b0, snap_h_reg})),
        .pad           ('0),
        .inverse_ratio (inverse_ratio_reg),
        .result        (h_u)
    );

    logic         m_tvalid_reg;
    logic [103:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (snap_advance) begin
            m_tvalid_reg <= snap_valid_reg && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_advance && snap_valid_reg) begin
            m_tdata_reg <= {3'b000,
                            h_u[SIZE_OUT_W-1:0],
                            w_u[SIZE_OUT_W-1:0],
                            top_u,
                            left_u,
                            score,
                            snap_class_reg,
                            snap_anchor_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- src/dhd_unscale.sv -----
// Removes letterbox padding from one box coordinate and scales it to original pixels.
module dhd_unscale
    import dhd_pkg::*;
(
    input  logic signed [COORD_W-1:0]    coord,
    input  logic        [PAD_W-1:0]      pad,
    input  logic        [RATIO_W-1:0]    inverse_ratio,
    output logic signed [EDGE_OUT_W-1:0] result
);

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + RATIO_W + 1;
    localparam int QUO_W  = PROD_W - FRAC_BITS;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] biased;
    logic signed [QUO_W-1:0]  quo;
    logic                     overflow;

    always_comb begin
        diff   = DIFF_W'(coord) - $signed({2'b00, pad});
        prod   = PROD_W'(diff) * $signed({{(PROD_W-RATIO_W){1'b0}}, inverse_ratio});
        // Bias negatives so the shift truncates toward zero
        biased = prod + $signed({{(PROD_W-FRAC_BITS){1'b0}},
                                 {FRAC_BITS{prod[PROD_W-1]}}});
        quo    = QUO_W'(biased >>> FRAC_BITS);
        overflow = (quo[QUO_W-1:EDGE_OUT_W-1] != {(QUO_W-EDGE_OUT_W+1){1'b0}}) &&
                   (quo[QUO_W-1:EDGE_OUT_W-1] != {(QUO_W-EDGE_OUT_W+1){1'b1}});
        if (overflow) begin
            result = quo[QUO_W-1] ? {1'b1, {(EDGE_OUT_W-1){1'b0}}}
                                  : {1'b0, {(EDGE_OUT_W-1){1'b1}}};
        end else begin
            result = quo[EDGE_OUT_W-1:0];
        end
    end

endmodule
